/* hw/rtl/gibt_pkg.sv */
// ----------------------------------------------------------------------------
// gibt_pkg
// Shared sizes, field widths, command codes, register indices and reset values of the greedy IoU box tracker.
// ----------------------------------------------------------------------------
package gibt_pkg;

  localparam int ND  = 32;                       // detection buffer depth
  localparam int NT  = 32;                       // track table depth
  localparam int DIW = $clog2(ND);
  localparam int TIW = $clog2(NT);
  localparam int CW  = ((DIW > TIW) ? DIW : TIW) + 1;

  localparam int IN_DW  = 88;
  localparam int OUT_DW = 136;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_EOF = 2'd1,
    CMD_CLR = 2'd2
  } cmd_t;

  localparam logic [7:0] REG_IOU_THR    = 8'd0;
  localparam logic [7:0] REG_MAX_MISSED = 8'd1;

  localparam logic [15:0] IOU_THR_RST    = 16'd19661;
  localparam logic [7:0]  MAX_MISSED_RST = 8'd30;

endpackage

/* hw/rtl/greedy_iou_box_tracker.sv */
// ----------------------------------------------------------------------------
// greedy_iou_box_tracker
// Frame-based greedy IoU tracker built around one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per cycle at most. tuser is the command (add
//           detection, end of frame, clear tracks), tdata the detection.
//           Add and clear give no result and keep in_tready high.
//   out_* : end of frame gives one result per active track in id order, or
//           one empty result; tlast marks the final one of the frame.
//   cfg_* : register writes, always ready; write only while the block idles.
// Sequence: end of frame runs per buffered detection a score scan, a
//   load, a track scan with the IoU of each eligible track on the shared
//   multiplier and, on a match, a track update; then it ages tracks,
//   places new tracks, counts active tracks and emits each track after a
//   scan for the lowest id. in_tready stays low from end of frame until
//   the sequencer leaves its finish state after the last result is loaded
//   into the output register.
// Reset: clears tracks, buffer count, ids and restores register defaults.
// Stall: the output register holds a result until taken; the sequencer
//   waits in place for it before loading the next one.
// ----------------------------------------------------------------------------
module greedy_iou_box_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // left, top, right, bottom, score, class
  input  logic [gibt_pkg::IN_DW-1:0]  in_tdata,
  // command
  input  logic [1:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // trk_id, left, top, right, bottom, score, class, matches
  output logic [gibt_pkg::OUT_DW-1:0] out_tdata,
  output logic                        out_tlast,
  // list_empty, overflow_flag
  output logic [1:0]                  out_tuser,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  cfg_index,
  input  logic [15:0]                 cfg_data
);

  localparam int ND  = gibt_pkg::ND;
  localparam int NT  = gibt_pkg::NT;
  localparam int DIW = gibt_pkg::DIW;
  localparam int TIW = gibt_pkg::TIW;
  localparam int CW  = gibt_pkg::CW;

  typedef enum logic [23:0] {
    S_IDLE    = 24'h000001,
    S_SORT    = 24'h000002,
    S_DLOAD   = 24'h000004,
    S_DCAP    = 24'h000008,
    S_M_RD    = 24'h000010,
    S_M_SPAN  = 24'h000020,
    S_M_MI    = 24'h000040,
    S_M_MA    = 24'h000080,
    S_M_MB    = 24'h000100,
    S_M_UN    = 24'h000200,
    S_M_TH    = 24'h000400,
    S_M_C1    = 24'h000800,
    S_M_C2    = 24'h001000,
    S_M_UPD   = 24'h002000,
    S_M_WR    = 24'h004000,
    S_AGE     = 24'h008000,
    S_OPEN    = 24'h010000,
    S_OPEN_WR = 24'h020000,
    S_COUNT   = 24'h040000,
    S_E_SCAN  = 24'h080000,
    S_E_RD    = 24'h100000,
    S_E_OUT   = 24'h200000,
    S_E_EMPTY = 24'h400000,
    S_FIN     = 24'h800000
  } state_t;

  function automatic logic [15:0] max16(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [15:0] span16(input logic [15:0] lo, input logic [15:0] hi);
    return (hi > lo) ? (hi - lo) : 16'd0;
  endfunction

  // memories
  logic [63:0] det_box_mem  [ND];
  logic [23:0] det_attr_mem [ND];
  logic [63:0] trk_box_mem  [NT];
  logic [39:0] trk_attr_mem [NT];
  logic [31:0] trk_id_mem   [NT];

  logic           det_we;
  logic [DIW-1:0] det_raddr;
  logic [63:0]    det_box_rd_r;
  logic [23:0]    det_attr_rd_r;
  logic           trk_we;
  logic           trk_we_id;
  logic [TIW-1:0] trk_waddr;
  logic [TIW-1:0] trk_raddr;
  logic [63:0]    trk_wbox;
  logic [39:0]    trk_wattr;
  logic [31:0]    trk_wid;
  logic [63:0]    trk_box_rd_r;
  logic [39:0]    trk_attr_rd_r;
  logic [31:0]    trk_id_rd_r;

  // control
  state_t        state_r, state_nxt;
  logic [CW-1:0] det_count_r, det_count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] lag_r, lag_nxt;
  logic          lag_v_r, lag_v_nxt;
  logic [CW-1:0] pick_r, pick_nxt;
  logic          pick_v_r, pick_v_nxt;
  logic [31:0]   pick_key_r, pick_key_nxt;
  logic [CW-1:0] fp_r, fp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ek_r, ek_nxt;
  logic [NT-1:0] valid_r, valid_nxt;
  logic [8:0]    missed_r [NT];
  logic [8:0]    missed_nxt [NT];
  logic [NT-1:0] claimed_r, claimed_nxt;
  logic [NT-1:0] sent_r, sent_nxt;
  logic [ND-1:0] matched_r, matched_nxt;
  logic [ND-1:0] done_r, done_nxt;
  logic [31:0]   next_id_r, next_id_nxt;
  logic          ovf_r, ovf_nxt;
  logic [15:0]   thr_r, thr_nxt;
  logic [7:0]    maxm_r, maxm_nxt;
  logic          out_valid_r, out_valid_nxt;

  // match datapath
  logic [63:0]    dbox_r, dbox_nxt;
  logic [23:0]    dattr_r, dattr_nxt;
  logic [TIW-1:0] cur_t_r, cur_t_nxt;
  logic [31:0]    cur_id_r, cur_id_nxt;
  logic [15:0]    wi_r, wi_nxt, hi_r, hi_nxt;
  logic [15:0]    wa_r, wa_nxt, ha_r, ha_nxt;
  logic [15:0]    wb_r, wb_nxt, hb_r, hb_nxt;
  logic [31:0]    in_r, in_nxt;
  logic [31:0]    aa_r, aa_nxt;
  logic [31:0]    ab_r, ab_nxt;
  logic [32:0]    un_r, un_nxt;
  logic [64:0]    p1_r, p1_nxt;
  logic           best_v_r, best_v_nxt;
  logic [TIW-1:0] best_t_r, best_t_nxt;
  logic [31:0]    best_id_r, best_id_nxt;
  logic [31:0]    bi_r, bi_nxt;
  logic [32:0]    bu_r, bu_nxt;
  logic [gibt_pkg::OUT_DW-1:0] out_data_r, out_data_nxt;
  logic           out_last_r, out_last_nxt;
  logic [1:0]     out_user_r, out_user_nxt;

  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;
  logic        out_free;

  assign prod      = mul_a * mul_b;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    logic [15:0] mcnt;
    logic        take;
    logic        last;

    state_nxt     = state_r;
    det_count_nxt = det_count_r;
    idx_nxt       = idx_r;
    lag_nxt       = lag_r;
    lag_v_nxt     = lag_v_r;
    pick_nxt      = pick_r;
    pick_v_nxt    = pick_v_r;
    pick_key_nxt  = pick_key_r;
    fp_nxt        = fp_r;
    cnt_nxt       = cnt_r;
    ek_nxt        = ek_r;
    valid_nxt     = valid_r;
    missed_nxt    = missed_r;
    claimed_nxt   = claimed_r;
    sent_nxt      = sent_r;
    matched_nxt   = matched_r;
    done_nxt      = done_r;
    next_id_nxt   = next_id_r;
    ovf_nxt       = ovf_r;
    thr_nxt       = thr_r;
    maxm_nxt      = maxm_r;
    out_valid_nxt = out_valid_r;
    dbox_nxt      = dbox_r;
    dattr_nxt     = dattr_r;
    cur_t_nxt     = cur_t_r;
    cur_id_nxt    = cur_id_r;
    wi_nxt = wi_r; hi_nxt = hi_r;
    wa_nxt = wa_r; ha_nxt = ha_r;
    wb_nxt = wb_r; hb_nxt = hb_r;
    in_nxt        = in_r;
    aa_nxt        = aa_r;
    ab_nxt        = ab_r;
    un_nxt        = un_r;
    p1_nxt        = p1_r;
    best_v_nxt    = best_v_r;
    best_t_nxt    = best_t_r;
    best_id_nxt   = best_id_r;
    bi_nxt        = bi_r;
    bu_nxt        = bu_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;

    det_we    = 1'b0;
    det_raddr = idx_r[DIW-1:0];
    trk_we    = 1'b0;
    trk_we_id = 1'b0;
    trk_waddr = best_t_r;
    trk_raddr = idx_r[TIW-1:0];
    trk_wbox  = dbox_r;
    trk_wattr = {16'd0, dattr_r};
    trk_wid   = next_id_r;
    mul_a     = '0;
    mul_b     = '0;
    mcnt      = trk_attr_rd_r[39:24];
    take      = 1'b0;
    last      = (ek_r == cnt_r - CW'(1));

    if (cfg_valid) begin
      if (cfg_index == gibt_pkg::REG_IOU_THR) thr_nxt = cfg_data;
      else if (cfg_index == gibt_pkg::REG_MAX_MISSED) maxm_nxt = cfg_data[7:0];
    end
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            gibt_pkg::CMD_ADD: begin
              if (det_count_r >= CW'(ND)) begin
                ovf_nxt = 1'b1;
              end else begin
                det_we        = 1'b1;
                det_count_nxt = det_count_r + CW'(1);
              end
            end
            gibt_pkg::CMD_EOF: begin
              idx_nxt    = '0;
              lag_v_nxt  = 1'b0;
              pick_v_nxt = 1'b0;
              state_nxt  = S_SORT;
            end
            gibt_pkg::CMD_CLR: begin
              valid_nxt   = '0;
              missed_nxt  = '{default: '0};
              claimed_nxt = '0;
              next_id_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_SORT: begin
        if (lag_v_r && (!pick_v_r || 32'(det_attr_rd_r[15:0]) > pick_key_r)) begin
          pick_v_nxt   = 1'b1;
          pick_nxt     = lag_r;
          pick_key_nxt = 32'(det_attr_rd_r[15:0]);
        end
        if (idx_r != det_count_r) begin
          lag_nxt   = idx_r;
          lag_v_nxt = !done_r[idx_r[DIW-1:0]];
          idx_nxt   = idx_r + CW'(1);
        end else begin
          lag_v_nxt = 1'b0;
          if (!lag_v_r) begin
            if (pick_v_r) begin
              done_nxt[pick_r[DIW-1:0]] = 1'b1;
              state_nxt = S_DLOAD;
            end else begin
              state_nxt = S_AGE;
            end
          end
        end
      end
      S_DLOAD: begin
        det_raddr = pick_r[DIW-1:0];
        state_nxt = S_DCAP;
      end
      S_DCAP: begin
        dbox_nxt   = det_box_rd_r;
        dattr_nxt  = det_attr_rd_r;
        idx_nxt    = '0;
        best_v_nxt = 1'b0;
        state_nxt  = S_M_RD;
      end
      S_M_RD: begin
        if (idx_r == CW'(NT)) begin
          if (best_v_r) begin
            state_nxt = S_M_UPD;
          end else begin
            idx_nxt    = '0;
            lag_v_nxt  = 1'b0;
            pick_v_nxt = 1'b0;
            state_nxt  = S_SORT;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
          if (valid_r[idx_r[TIW-1:0]] && missed_r[idx_r[TIW-1:0]] == 9'd0 &&
              !claimed_r[idx_r[TIW-1:0]]) begin
            cur_t_nxt = idx_r[TIW-1:0];
            state_nxt = S_M_SPAN;
          end
        end
      end
      S_M_SPAN: begin
        wi_nxt = span16(max16(dbox_r[15:0], trk_box_rd_r[15:0]),
                        min16(dbox_r[47:32], trk_box_rd_r[47:32]));
        hi_nxt = span16(max16(dbox_r[31:16], trk_box_rd_r[31:16]),
                        min16(dbox_r[63:48], trk_box_rd_r[63:48]));
        wa_nxt = span16(dbox_r[15:0], dbox_r[47:32]);
        ha_nxt = span16(dbox_r[31:16], dbox_r[63:48]);
        wb_nxt = span16(trk_box_rd_r[15:0], trk_box_rd_r[47:32]);
        hb_nxt = span16(trk_box_rd_r[31:16], trk_box_rd_r[63:48]);
        cur_id_nxt = trk_id_rd_r;
        state_nxt  = S_M_MI;
      end
      S_M_MI: begin
        mul_a = 33'(wi_r); mul_b = 33'(hi_r);
        in_nxt    = prod[31:0];
        state_nxt = S_M_MA;
      end
      S_M_MA: begin
        mul_a = 33'(wa_r); mul_b = 33'(ha_r);
        aa_nxt    = prod[31:0];
        state_nxt = S_M_MB;
      end
      S_M_MB: begin
        mul_a = 33'(wb_r); mul_b = 33'(hb_r);
        ab_nxt    = prod[31:0];
        state_nxt = S_M_UN;
      end
      S_M_UN: begin
        un_nxt    = 33'(aa_r) + 33'(ab_r) - 33'(in_r);
        state_nxt = S_M_TH;
      end
      S_M_TH: begin
        mul_a = 33'(thr_r); mul_b = un_r;
        state_nxt = S_M_RD;
        if (un_r != 33'd0 && 66'({in_r, 16'd0}) > prod) begin
          if (!best_v_r) take = 1'b1;
          else state_nxt = S_M_C1;
        end
      end
      S_M_C1: begin
        mul_a = 33'(in_r); mul_b = bu_r;
        p1_nxt    = prod[64:0];
        state_nxt = S_M_C2;
      end
      S_M_C2: begin
        mul_a = 33'(bi_r); mul_b = un_r;
        if (p1_r > prod[64:0] || (p1_r == prod[64:0] && cur_id_r < best_id_r)) take = 1'b1;
        state_nxt = S_M_RD;
      end
      S_M_UPD: begin
        trk_raddr = best_t_r;
        state_nxt = S_M_WR;
      end
      S_M_WR: begin
        trk_we    = 1'b1;
        trk_waddr = best_t_r;
        trk_wattr = {(mcnt == 16'hFFFF) ? mcnt : mcnt + 16'd1, dattr_r};
        claimed_nxt[best_t_r]        = 1'b1;
        missed_nxt[best_t_r]         = 9'd0;
        matched_nxt[pick_r[DIW-1:0]] = 1'b1;
        idx_nxt    = '0;
        lag_v_nxt  = 1'b0;
        pick_v_nxt = 1'b0;
        state_nxt  = S_SORT;
      end
      S_AGE: begin
        for (int t = 0; t < NT; t++) begin
          if (valid_r[t] && !claimed_r[t]) begin
            if (missed_r[t] + 9'd1 > 9'(maxm_r)) begin
              valid_nxt[t]  = 1'b0;
              missed_nxt[t] = 9'd0;
            end else begin
              missed_nxt[t] = missed_r[t] + 9'd1;
            end
          end
        end
        idx_nxt   = '0;
        fp_nxt    = '0;
        state_nxt = S_OPEN;
      end
      S_OPEN: begin
        if (idx_r == det_count_r) begin
          idx_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_COUNT;
        end else if (matched_r[idx_r[DIW-1:0]]) begin
          idx_nxt = idx_r + CW'(1);
        end else if (fp_r == CW'(NT)) begin
          ovf_nxt = 1'b1;
          idx_nxt = idx_r + CW'(1);
        end else if (valid_r[fp_r[TIW-1:0]]) begin
          fp_nxt = fp_r + CW'(1);
        end else begin
          state_nxt = S_OPEN_WR;
        end
      end
      S_OPEN_WR: begin
        trk_we    = 1'b1;
        trk_we_id = 1'b1;
        trk_waddr = fp_r[TIW-1:0];
        trk_wbox  = det_box_rd_r;
        trk_wattr = {16'd1, det_attr_rd_r};
        valid_nxt[fp_r[TIW-1:0]]  = 1'b1;
        missed_nxt[fp_r[TIW-1:0]] = 9'd0;
        next_id_nxt = next_id_r + 32'd1;
        fp_nxt      = fp_r + CW'(1);
        idx_nxt     = idx_r + CW'(1);
        state_nxt   = S_OPEN;
      end
      S_COUNT: begin
        if (idx_r == CW'(NT)) begin
          if (cnt_r == '0) begin
            state_nxt = S_E_EMPTY;
          end else begin
            ek_nxt     = '0;
            sent_nxt   = '0;
            idx_nxt    = '0;
            lag_v_nxt  = 1'b0;
            pick_v_nxt = 1'b0;
            state_nxt  = S_E_SCAN;
          end
        end else begin
          if (valid_r[idx_r[TIW-1:0]] && missed_r[idx_r[TIW-1:0]] == 9'd0)
            cnt_nxt = cnt_r + CW'(1);
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_E_SCAN: begin
        if (lag_v_r && (!pick_v_r || trk_id_rd_r < pick_key_r)) begin
          pick_v_nxt   = 1'b1;
          pick_nxt     = lag_r;
          pick_key_nxt = trk_id_rd_r;
        end
        if (idx_r != CW'(NT)) begin
          lag_nxt   = idx_r;
          lag_v_nxt = valid_r[idx_r[TIW-1:0]] && missed_r[idx_r[TIW-1:0]] == 9'd0 &&
                      !sent_r[idx_r[TIW-1:0]];
          idx_nxt   = idx_r + CW'(1);
        end else begin
          lag_v_nxt = 1'b0;
          if (!lag_v_r) state_nxt = S_E_RD;
        end
      end
      S_E_RD: begin
        trk_raddr = pick_r[TIW-1:0];
        state_nxt = S_E_OUT;
      end
      S_E_OUT: begin
        trk_raddr = pick_r[TIW-1:0];
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {trk_attr_rd_r, trk_box_rd_r, trk_id_rd_r};
          out_last_nxt  = last;
          out_user_nxt  = {ovf_r, 1'b0};
          sent_nxt[pick_r[TIW-1:0]] = 1'b1;
          ek_nxt = ek_r + CW'(1);
          if (last) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt    = '0;
            lag_v_nxt  = 1'b0;
            pick_v_nxt = 1'b0;
            state_nxt  = S_E_SCAN;
          end
        end
      end
      S_E_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_user_nxt  = {ovf_r, 1'b1};
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        det_count_nxt = '0;
        ovf_nxt       = 1'b0;
        claimed_nxt   = '0;
        done_nxt      = '0;
        matched_nxt   = '0;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (take) begin
      best_v_nxt  = 1'b1;
      best_t_nxt  = cur_t_r;
      best_id_nxt = cur_id_r;
      bi_nxt      = in_r;
      bu_nxt      = un_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      det_count_r <= '0;
      idx_r       <= '0;
      lag_v_r     <= 1'b0;
      pick_v_r    <= 1'b0;
      fp_r        <= '0;
      cnt_r       <= '0;
      ek_r        <= '0;
      valid_r     <= '0;
      missed_r    <= '{default: '0};
      claimed_r   <= '0;
      sent_r      <= '0;
      matched_r   <= '0;
      done_r      <= '0;
      next_id_r   <= '0;
      ovf_r       <= 1'b0;
      thr_r       <= gibt_pkg::IOU_THR_RST;
      maxm_r      <= gibt_pkg::MAX_MISSED_RST;
      out_valid_r <= 1'b0;
      best_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      det_count_r <= det_count_nxt;
      idx_r       <= idx_nxt;
      lag_v_r     <= lag_v_nxt;
      pick_v_r    <= pick_v_nxt;
      fp_r        <= fp_nxt;
      cnt_r       <= cnt_nxt;
      ek_r        <= ek_nxt;
      valid_r     <= valid_nxt;
      missed_r    <= missed_nxt;
      claimed_r   <= claimed_nxt;
      sent_r      <= sent_nxt;
      matched_r   <= matched_nxt;
      done_r      <= done_nxt;
      next_id_r   <= next_id_nxt;
      ovf_r       <= ovf_nxt;
      thr_r       <= thr_nxt;
      maxm_r      <= maxm_nxt;
      out_valid_r <= out_valid_nxt;
      best_v_r    <= best_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lag_r      <= lag_nxt;
    pick_r     <= pick_nxt;
    pick_key_r <= pick_key_nxt;
    dbox_r     <= dbox_nxt;
    dattr_r    <= dattr_nxt;
    cur_t_r    <= cur_t_nxt;
    cur_id_r   <= cur_id_nxt;
    wi_r <= wi_nxt; hi_r <= hi_nxt;
    wa_r <= wa_nxt; ha_r <= ha_nxt;
    wb_r <= wb_nxt; hb_r <= hb_nxt;
    in_r       <= in_nxt;
    aa_r       <= aa_nxt;
    ab_r       <= ab_nxt;
    un_r       <= un_nxt;
    p1_r       <= p1_nxt;
    best_t_r   <= best_t_nxt;
    best_id_r  <= best_id_nxt;
    bi_r       <= bi_nxt;
    bu_r       <= bu_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  // detection buffer
  always_ff @(posedge clk) begin
    if (det_we) begin
      det_box_mem[det_count_r[DIW-1:0]]  <= in_tdata[63:0];
      det_attr_mem[det_count_r[DIW-1:0]] <= in_tdata[87:64];
    end
    det_box_rd_r  <= det_box_mem[det_raddr];
    det_attr_rd_r <= det_attr_mem[det_raddr];
  end

  // track table
  always_ff @(posedge clk) begin
    if (trk_we) begin
      trk_box_mem[trk_waddr]  <= trk_wbox;
      trk_attr_mem[trk_waddr] <= trk_wattr;
    end
    if (trk_we_id) trk_id_mem[trk_waddr] <= trk_wid;
    trk_box_rd_r  <= trk_box_mem[trk_raddr];
    trk_attr_rd_r <= trk_attr_mem[trk_raddr];
    trk_id_rd_r   <= trk_id_mem[trk_raddr];
  end

endmodule

/* hw/rtl/gibt_checker.sv */
// ----------------------------------------------------------------------------
// gibt_checker
// Port-level checks of the greedy IoU box tracker, bound to the top level.
// ----------------------------------------------------------------------------
module gibt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [1:0]                  in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [gibt_pkg::OUT_DW-1:0] out_tdata,
  input logic                        out_tlast,
  input logic [1:0]                  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && out_tdata == '0)
    else $error("empty result not final or not zero");

  a_eof_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == gibt_pkg::CMD_EOF |=> !in_tready)
    else $error("input taken during end of frame");

  a_add_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == gibt_pkg::CMD_ADD |=> in_tready)
    else $error("add request left the block busy");

endmodule

bind greedy_iou_box_tracker gibt_checker u_gibt_checker (.*);
